### rtl/cxp_pkg.sv
// cxp_pkg: types, constants and CORDIC helpers for the coordinate x projection
// no dependencies; imported by the interfaces' users and the top level
`timescale 1ns / 1ps
`default_nettype none

package cxp_pkg;

  localparam int SYS_W = 3;
  localparam int VAL_W = 32;
  localparam int ANG_W = 16;
  localparam int CW = 34;    // cordic datapath width
  localparam int TW = 33;    // trig result width, Q2.30 plus margin
  localparam int PW = 66;    // product width
  localparam int ATAN_ENTRIES = 24;

  localparam logic [SYS_W-1:0] SYS_CART = 3'd0;
  localparam logic [SYS_W-1:0] SYS_UNIT_SPH = 3'd1;
  localparam logic [SYS_W-1:0] SYS_SPH = 3'd2;
  localparam logic [SYS_W-1:0] SYS_POLAR = 3'd3;

  localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sh026DD3B6A;

  localparam logic [31:0] ATAN_TABLE [ATAN_ENTRIES] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  typedef struct packed {
    logic                 neg;
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
  } cordic_t;

  typedef struct packed {
    logic [SYS_W-1:0]        sys;
    logic signed [VAL_W-1:0] opnd;  // cart_x for cartesian points, radius otherwise
  } meta_t;

  typedef struct packed {
    logic signed [TW-1:0] ct;
    logic signed [TW-1:0] st;
    logic signed [TW-1:0] cp;
  } trig_t;

  // fold the angle into [-quarter, +quarter) and start the rotation
  function automatic cordic_t cordic_prep(logic [ANG_W-1:0] a);
    cordic_t c;
    c.neg = a[ANG_W-1] ^ a[ANG_W-2];
    c.x = CORDIC_GAIN;
    c.y = '0;
    c.z = $signed({{(CW-2*ANG_W+1){a[ANG_W-2]}}, a[ANG_W-2:0], 16'b0});
    return c;
  endfunction

  function automatic cordic_t cordic_iter(cordic_t c, int i);
    cordic_t n;
    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;
    logic signed [CW-1:0] da;
    n = c;
    dx = c.y >>> i;
    dy = c.x >>> i;
    da = $signed({2'b00, ATAN_TABLE[i]});
    if (!c.z[CW-1]) begin
      n.x = c.x - dx;
      n.y = c.y + dy;
      n.z = c.z - da;
    end else begin
      n.x = c.x + dx;
      n.y = c.y - dy;
      n.z = c.z + da;
    end
    return n;
  endfunction

endpackage

`default_nettype wire

### rtl/cxp_if.sv
// cxp_in_if, cxp_out_if: valid/ready channels of the coordinate x projection
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

interface cxp_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         system;
  logic signed [31:0] cart_x;
  logic signed [31:0] radius;
  logic signed [15:0] polar_angle;
  logic signed [15:0] azimuth;

  modport source (output valid, system, cart_x, radius, polar_angle, azimuth, input ready);
  modport sink (input valid, system, cart_x, radius, polar_angle, azimuth, output ready);
endinterface

interface cxp_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] x_value;
  logic               status;

  modport source (output valid, x_value, status, input ready);
  modport sink (input valid, x_value, status, output ready);
endinterface

`default_nettype wire

### rtl/coordinate_x_projection.sv
// coordinate_x_projection: cartesian x of a point given as cartesian, unit
// spherical, spherical or polar/cylindrical coordinates; needs cxp_pkg, cxp_if
//
// usage:
//   in_ch  beat: system code, cart_x, radius (Q16.16), theta and phi (16-bit
//          binary angles). out_ch beat: x_value (Q16.16) and status (1 on an
//          unknown system code, with x_value zero). one result per input beat,
//          in order.
//   stages: N being TRIG_ITERATIONS capped at 24, the pipeline holds one
//          setup stage, one rotation stage per iteration for theta and phi
//          side by side, a sign fix stage, two multiplier stages and the
//          output register.
//   throughput: one beat per cycle unless stalled; every stage holds a valid bit and
//          moves on when the stage after it is empty or moving, so bubbles close up.
//   stall: when out_ch.ready is low the result holds and stages behind fill up;
//          in_ch.ready falls only when every stage is occupied.
//   reset: synchronous rst_n clears all valid bits; nothing else needs reset.
`timescale 1ns / 1ps
`default_nettype none

module coordinate_x_projection
  import cxp_pkg::*;
#(
  parameter int TRIG_ITERATIONS = 16
) (
  input  wire        clk,
  input  wire        rst_n,
  cxp_in_if.sink     in_ch,
  cxp_out_if.source  out_ch
);

  localparam int N = (TRIG_ITERATIONS > ATAN_ENTRIES) ? ATAN_ENTRIES : TRIG_ITERATIONS;
  localparam int L = N + 5;
  localparam int ST_FIX = N + 1;
  localparam int ST_M1 = N + 2;
  localparam int ST_M2 = N + 3;
  localparam logic signed [35:0] SAT_MAX = 36'sh07FFFFFFF;
  localparam logic signed [35:0] SAT_MIN = -36'sh080000000;

  logic [L-1:0] v_r;
  logic [L-1:0] adv;
  logic [L-1:0] v_in;

  cordic_t th_r [N+1];
  cordic_t ph_r [N+1];
  meta_t   meta_r [N+4];
  trig_t   trig_r;
  logic signed [PW-1:0] p1_r;
  logic signed [PW-1:0] w_r;
  logic signed [VAL_W-1:0] x_value_r;
  logic status_r;

  // stall chain
  always_comb begin
    adv[L-1] = !v_r[L-1] || out_ch.ready;
    for (int k = L - 2; k >= 0; k--) begin
      adv[k] = !v_r[k] || adv[k+1];
    end
  end

  assign v_in = {v_r[L-2:0], in_ch.valid};
  assign in_ch.ready = adv[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int k = 0; k < L; k++) begin
        if (adv[k]) begin
          v_r[k] <= v_in[k];
        end
      end
    end
  end

  // setup stage
  always_ff @(posedge clk) begin
    if (adv[0]) begin
      th_r[0] <= cordic_prep(in_ch.polar_angle);
      ph_r[0] <= cordic_prep(in_ch.azimuth);
      meta_r[0].sys <= in_ch.system;
      meta_r[0].opnd <= (in_ch.system == SYS_CART) ? in_ch.cart_x : in_ch.radius;
    end
  end

  // rotation stages
  for (genvar gk = 1; gk <= N; gk++) begin : g_rot
    always_ff @(posedge clk) begin
      if (adv[gk]) begin
        th_r[gk] <= cordic_iter(th_r[gk-1], gk - 1);
        ph_r[gk] <= cordic_iter(ph_r[gk-1], gk - 1);
      end
    end
  end

  for (genvar gm = 1; gm <= ST_M2; gm++) begin : g_meta
    always_ff @(posedge clk) begin
      if (adv[gm]) begin
        meta_r[gm] <= meta_r[gm-1];
      end
    end
  end

  // sign fix
  logic signed [CW-1:0] ct_full;
  logic signed [CW-1:0] st_full;
  logic signed [CW-1:0] cp_full;

  always_comb begin
    ct_full = th_r[N].neg ? -th_r[N].x : th_r[N].x;
    st_full = th_r[N].neg ? -th_r[N].y : th_r[N].y;
    cp_full = ph_r[N].neg ? -ph_r[N].x : ph_r[N].x;
  end

  always_ff @(posedge clk) begin
    if (adv[ST_FIX]) begin
      trig_r.ct <= ct_full[TW-1:0];
      trig_r.st <= st_full[TW-1:0];
      trig_r.cp <= cp_full[TW-1:0];
    end
  end

  // first product: sin_t * cos_p, or radius * cos_t for polar points
  logic signed [TW-1:0] m1_a;
  logic signed [TW-1:0] m1_b;
  logic signed [PW-1:0] m1_p;

  always_comb begin
    if (meta_r[ST_FIX].sys == SYS_POLAR) begin
      m1_a = TW'(meta_r[ST_FIX].opnd);
      m1_b = trig_r.ct;
    end else begin
      m1_a = trig_r.st;
      m1_b = trig_r.cp;
    end
    m1_p = m1_a * m1_b;
  end

  always_ff @(posedge clk) begin
    if (adv[ST_M1]) begin
      p1_r <= m1_p;
    end
  end

  // second product, aligned so the output stage always shifts by 30
  logic signed [TW-1:0] sc;
  logic signed [TW-1:0] m2_a;
  logic signed [PW-1:0] m2_p;
  logic signed [PW-1:0] w_nxt;

  always_comb begin
    sc = $signed(p1_r[30+TW-1:30]);
    m2_a = TW'(meta_r[ST_M1].opnd);
    m2_p = m2_a * sc;
    case (meta_r[ST_M1].sys)
      SYS_CART:     w_nxt = PW'(meta_r[ST_M1].opnd) <<< 30;
      SYS_UNIT_SPH: w_nxt = PW'(sc) <<< 16;
      SYS_SPH:      w_nxt = m2_p;
      SYS_POLAR:    w_nxt = p1_r;
      default:      w_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv[ST_M2]) begin
      w_r <= w_nxt;
    end
  end

  // shift, saturate, output register
  logic signed [35:0] t_shift;
  logic signed [VAL_W-1:0] x_value_nxt;
  logic status_nxt;

  always_comb begin
    t_shift = $signed(w_r[PW-1:30]);
    status_nxt = (meta_r[ST_M2].sys > SYS_POLAR);
    if (t_shift > SAT_MAX) begin
      x_value_nxt = SAT_MAX[VAL_W-1:0];
    end else if (t_shift < SAT_MIN) begin
      x_value_nxt = SAT_MIN[VAL_W-1:0];
    end else begin
      x_value_nxt = t_shift[VAL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv[L-1]) begin
      x_value_r <= x_value_nxt;
      status_r <= status_nxt;
    end
  end

  assign out_ch.valid = v_r[L-1];
  assign out_ch.x_value = x_value_r;
  assign out_ch.status = status_r;

  // checks
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.status |-> out_ch.x_value == '0)
    else $error("unknown system code with nonzero x");

  a_full_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (&v_r) && !out_ch.ready |-> !in_ch.ready)
    else $error("input taken while pipeline full and stalled");

  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !v_r[0] |-> in_ch.ready)
    else $error("empty entry stage refuses input");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_ch.valid)
    else $error("output valid after reset");

endmodule

`default_nettype wire

### tb/tb_top.sv
// tb_top: self-checking bench for coordinate_x_projection, with a cordic-based predictor
// of the projected x; needs cxp_pkg, cxp_in_if / cxp_out_if and the top level
`timescale 1ns / 1ps

module tb_top;
  import cxp_pkg::*;

  localparam int ITERS = 16;
  localparam int ROT_STEPS = (ITERS < 24) ? ITERS : 24;
  localparam int DRAIN_CYCLES = ROT_STEPS + 5 + 20;
  localparam int LONG_HOLD = 64;
  localparam int BACKPRESSURE_ITEMS = 80;
  localparam int RANDOM_ITEMS = 1750;

  localparam logic STATUS_OK = 1'b0;
  localparam logic STATUS_UNKNOWN = 1'b1;

  localparam longint GAIN_Q30 = 64'sh26DD3B6A;
  localparam longint ARCTAN_TURN32 [24] = '{
    64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43, 64'h0145D7E1,
    64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
    64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D, 64'h000028BE, 64'h0000145F,
    64'h00000A30, 64'h00000518, 64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051
  };

  typedef struct packed {
    logic [SYS_W-1:0]        system;
    logic signed [VAL_W-1:0] cart_x;
    logic signed [VAL_W-1:0] radius;
    logic signed [ANG_W-1:0] polar_angle;
    logic signed [ANG_W-1:0] azimuth;
  } point_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] x_value;
    logic                    status;
  } x_result_t;

  typedef enum logic [1:0] {SINK_ALWAYS, SINK_PATTERN, SINK_RANDOM} sink_mode_t;

  logic clk;
  logic rst_n;

  cxp_in_if  in_ch();
  cxp_out_if out_ch();

  coordinate_x_projection #(
    .TRIG_ITERATIONS(ITERS)
  ) u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  x_result_t  pending_x_q[$];
  int         mismatch_count = 0;
  sink_mode_t sink_mode = SINK_ALWAYS;
  bit         long_hold_req = 1'b0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // cos and sin of a 16-bit binary angle, q2.30
  function automatic void angle_trig(input logic [ANG_W-1:0] ang, output longint cos_q30,
                                     output longint sin_q30);
    logic [31:0] turn;
    logic        flip;
    longint      x;
    longint      y;
    longint      z;
    longint      dx;
    longint      dy;
    turn = {ang, 16'h0000};
    flip = turn[31] ^ turn[30];
    if (flip) begin
      turn = turn - 32'h8000_0000;
    end
    x = GAIN_Q30;
    y = 0;
    z = $signed(turn);
    for (int i = 0; i < ROT_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - ARCTAN_TURN32[i];
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + ARCTAN_TURN32[i];
      end
    end
    cos_q30 = flip ? -x : x;
    sin_q30 = flip ? -y : y;
  endfunction

  function automatic logic signed [VAL_W-1:0] clamp_q16(input longint v);
    if (v > 64'sd2147483647) begin
      return 32'sh7FFF_FFFF;
    end
    if (v < -64'sd2147483648) begin
      return 32'sh8000_0000;
    end
    return v[VAL_W-1:0];
  endfunction

  function automatic x_result_t project_x(input point_t p);
    x_result_t r;
    longint    ct;
    longint    st;
    longint    cp;
    longint    sp;
    longint    sc;
    longint    rad;
    rad = p.radius;
    r.status = STATUS_OK;
    r.x_value = '0;
    case (p.system)
      SYS_CART: begin
        r.x_value = p.cart_x;
      end
      SYS_UNIT_SPH: begin
        angle_trig(p.polar_angle, ct, st);
        angle_trig(p.azimuth, cp, sp);
        sc = (st * cp) >>> 30;
        r.x_value = clamp_q16(sc >>> 14);
      end
      SYS_SPH: begin
        angle_trig(p.polar_angle, ct, st);
        angle_trig(p.azimuth, cp, sp);
        sc = (st * cp) >>> 30;
        r.x_value = clamp_q16((rad * sc) >>> 30);
      end
      SYS_POLAR: begin
        angle_trig(p.polar_angle, ct, st);
        r.x_value = clamp_q16((rad * ct) >>> 30);
      end
      default: begin
        r.status = STATUS_UNKNOWN;
      end
    endcase
    return r;
  endfunction

  function automatic point_t point_of(input logic [SYS_W-1:0] sys, input logic [31:0] cx,
                                      input logic [31:0] rad, input logic [15:0] th,
                                      input logic [15:0] ph);
    point_t p;
    p.system = sys;
    p.cart_x = cx;
    p.radius = rad;
    p.polar_angle = th;
    p.azimuth = ph;
    return p;
  endfunction

  function automatic logic [31:0] random_q16();
    case ($urandom_range(0, 11))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'($urandom_range(0, 32'h0002_0000));
      3: return -32'($urandom_range(0, 32'h0002_0000));
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [15:0] random_angle();
    case ($urandom_range(0, 15))
      0: return 16'h0000;
      1: return 16'h4000;
      2: return 16'hC000;
      3: return 16'h8000;
      4: return 16'h7FFF;
      5: return 16'h3FFF;
      6: return 16'hBFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic point_t random_point();
    int               pick;
    logic [SYS_W-1:0] sys;
    pick = $urandom_range(0, 19);
    if (pick < 3) begin
      sys = SYS_CART;
    end else if (pick < 8) begin
      sys = SYS_UNIT_SPH;
    end else if (pick < 13) begin
      sys = SYS_SPH;
    end else if (pick < 18) begin
      sys = SYS_POLAR;
    end else begin
      sys = SYS_POLAR + 3'($urandom_range(1, 4));
    end
    return point_of(sys, random_q16(), random_q16(), random_angle(), random_angle());
  endfunction

  // leaves valid high so the next beat can follow back to back
  task automatic send_point(input point_t p);
    in_ch.valid <= 1'b1;
    in_ch.system <= p.system;
    in_ch.cart_x <= p.cart_x;
    in_ch.radius <= p.radius;
    in_ch.polar_angle <= p.polar_angle;
    in_ch.azimuth <= p.azimuth;
    @(posedge clk);
    while (!in_ch.ready) begin
      @(posedge clk);
    end
    pending_x_q.push_back(project_x(p));
  endtask

  task automatic pause_sender(input int cycles);
    if (cycles > 0) begin
      in_ch.valid <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  task automatic wait_for_results();
    pause_sender(1);
    while (pending_x_q.size() != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic test_cartesian_passthrough();
    send_point(point_of(SYS_CART, 32'h7FFF_FFFF, 32'h1234_5678, 16'h1111, 16'h2222));
    send_point(point_of(SYS_CART, 32'h8000_0000, 32'h8000_0000, 16'h8000, 16'h8000));
    send_point(point_of(SYS_CART, 32'h0000_0000, 32'h7FFF_FFFF, 16'h7FFF, 16'h7FFF));
    send_point(point_of(SYS_CART, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF));
  endtask

  task automatic test_unknown_codes();
    for (int c = SYS_POLAR + 1; c < (1 << SYS_W); c++) begin
      send_point(point_of(SYS_W'(c), random_q16(), random_q16(), random_angle(),
                          random_angle()));
    end
  endtask

  // angle fold boundaries plus gain overshoot into saturation
  task automatic test_trig_extremes();
    send_point(point_of(SYS_UNIT_SPH, 32'h0, 32'h0, 16'h4000, 16'h0000));
    send_point(point_of(SYS_UNIT_SPH, 32'h0, 32'h0, 16'hC000, 16'h8000));
    send_point(point_of(SYS_UNIT_SPH, 32'h0, 32'h0, 16'h8000, 16'h4000));
    send_point(point_of(SYS_UNIT_SPH, 32'h0, 32'h0, 16'h7FFF, 16'h7FFF));
    send_point(point_of(SYS_SPH, 32'h0, 32'h7FFF_FFFF, 16'h4000, 16'h0000));
    send_point(point_of(SYS_SPH, 32'h0, 32'h8000_0000, 16'h4000, 16'h0000));
    send_point(point_of(SYS_SPH, 32'h0, 32'h8000_0000, 16'h4000, 16'h8000));
    send_point(point_of(SYS_SPH, 32'h0, 32'h7FFF_FFFF, 16'hC000, 16'h8000));
    send_point(point_of(SYS_POLAR, 32'h0, 32'h7FFF_FFFF, 16'h0000, 16'h0000));
    send_point(point_of(SYS_POLAR, 32'h0, 32'h8000_0000, 16'h0000, 16'h0000));
    send_point(point_of(SYS_POLAR, 32'h0, 32'h8000_0000, 16'h8000, 16'h0000));
    send_point(point_of(SYS_POLAR, 32'h0, 32'h7FFF_FFFF, 16'h4000, 16'h0000));
    send_point(point_of(SYS_POLAR, 32'h0, 32'h00BC_614E, 16'h3FFF, 16'h0000));
    send_point(point_of(SYS_POLAR, 32'h0, 32'hFF43_9EB2, 16'hBFFF, 16'hFFFF));
  endtask

  // sink holds off long enough to fill every stage while beats keep coming
  task automatic test_backpressure();
    sink_mode = SINK_ALWAYS;
    long_hold_req = 1'b1;
    for (int n = 0; n < BACKPRESSURE_ITEMS; n++) begin
      send_point(random_point());
    end
  endtask

  task automatic test_random_traffic();
    int sent;
    int burst;
    int gap;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      case ((sent / 250) % 4)
        0: sink_mode = SINK_RANDOM;
        1: sink_mode = SINK_PATTERN;
        2: sink_mode = SINK_ALWAYS;
        default: sink_mode = SINK_RANDOM;
      endcase
      burst = $urandom_range(1, 24);
      for (int b = 0; b < burst && sent < RANDOM_ITEMS; b++) begin
        send_point(random_point());
        sent++;
      end
      if ((sent / 250) % 4 == 2) begin
        gap = 0;
      end else begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      end
      pause_sender(gap);
    end
  endtask

  initial begin : sink_ready
    int          phase;
    logic [15:0] mask;
    phase = 0;
    mask = 16'b1110_1101_0111_0011;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
      case (sink_mode)
        SINK_ALWAYS: out_ch.ready <= 1'b1;
        SINK_PATTERN: begin
          out_ch.ready <= mask[phase];
          phase = (phase + 1) % 16;
        end
        default: out_ch.ready <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  always @(posedge clk) begin : check_results
    x_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_x_q.size() == 0) begin
        $display("%0t: unexpected beat x_value %h status %b", $time, out_ch.x_value,
                 out_ch.status);
        mismatch_count++;
      end else begin
        want = pending_x_q.pop_front();
        if (out_ch.x_value !== want.x_value) begin
          $display("%0t: x_value expected %h actual %h", $time, want.x_value,
                   out_ch.x_value);
          mismatch_count++;
        end
        if (out_ch.status !== want.status) begin
          $display("%0t: status expected %b actual %b", $time, want.status, out_ch.status);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.system <= '0;
    in_ch.cart_x <= '0;
    in_ch.radius <= '0;
    in_ch.polar_angle <= '0;
    in_ch.azimuth <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_cartesian_passthrough();
    test_unknown_codes();
    test_trig_extremes();
    wait_for_results();
    test_backpressure();
    wait_for_results();
    test_random_traffic();
    wait_for_results();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_x_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin : watchdog
    #10_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

### coordinate_x_projection.f
rtl/cxp_pkg.sv
rtl/cxp_if.sv
rtl/coordinate_x_projection.sv
tb/tb_top.sv
